FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define HCPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define HCPR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/hcpr_pkg.sv
// Shared types and constants of the hires colour pixel renderer.
`default_nettype none
package hcpr_pkg;

    localparam int BYTES_PER_LINE  = 40;
    localparam int PIXELS_PER_BYTE = 7;
    localparam int COL_W           = 6;
    localparam int LINE_W          = 8;
    localparam int X_W             = 9;
    localparam int IDX_W           = 3;
    localparam int WIN_W           = PIXELS_PER_BYTE + 2;
    localparam int Q_DEPTH         = 4;
    localparam int Q_AW            = 2;
    localparam int Q_CW            = 3;

    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(BYTES_PER_LINE - 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(PIXELS_PER_BYTE - 1);
    localparam int               GROUP_BIT  = 7;

    typedef enum logic [2:0] {
        C_BLACK  = 3'd0,
        C_WHITE  = 3'd1,
        C_VIOLET = 3'd2,
        C_GREEN  = 3'd3,
        C_BLUE   = 3'd4,
        C_ORANGE = 3'd5
    } t_colour;

    // One byte ready to draw: its 9-bit neighbour window and placement.
    typedef struct packed {
        logic [WIN_W-1:0]  win;
        logic              group;
        logic [X_W-1:0]    xbase;
        logic [LINE_W-1:0] line;
        logic              last;
    } t_job;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

FILE: design/hcpr_front.sv
// Front end: accepts bytes, tracks the held byte and builds draw jobs.
`default_nettype none
module hcpr_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_pixel_byte,
    input  wire logic [hcpr_pkg::COL_W-1:0]  i_column,
    input  wire logic [hcpr_pkg::LINE_W-1:0] i_line,
    input  wire hcpr_pkg::t_q_status         i_q_status,
    output logic                             o_push,
    output hcpr_pkg::t_job                   o_push_job
);

    logic [7:0]                  r_held_byte;
    logic                        r_held_valid;
    logic [hcpr_pkg::LINE_W-1:0] r_held_line;
    logic [hcpr_pkg::COL_W-1:0]  r_held_col;
    logic                        r_bit_before;
    hcpr_pkg::t_job              r_pend;
    logic                        r_pend_valid;

    logic           w_acc;
    logic           w_follows;
    logic           w_has_b;
    logic           w_prev;
    hcpr_pkg::t_job w_job_a;
    hcpr_pkg::t_job w_job_b;

    assign o_in_stall = r_pend_valid || i_q_status.full;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_follows  = r_held_valid && (i_line == r_held_line)
                        && ({1'b0, i_column} == ({1'b0, r_held_col} + 7'd1));
    assign w_has_b    = (i_column >= hcpr_pkg::LAST_COL);
    assign w_prev     = w_follows && (i_column != '0) && r_held_byte[6];

    always_comb begin
        w_job_a.win   = {w_follows && i_pixel_byte[0], r_held_byte[6:0], r_bit_before};
        w_job_a.group = r_held_byte[hcpr_pkg::GROUP_BIT];
        w_job_a.xbase = {r_held_col, 3'b000} - {3'b000, r_held_col};
        w_job_a.line  = r_held_line;
        w_job_a.last  = !w_has_b;

        w_job_b.win   = {1'b0, i_pixel_byte[6:0], w_prev};
        w_job_b.group = i_pixel_byte[hcpr_pkg::GROUP_BIT];
        w_job_b.xbase = {i_column, 3'b000} - {3'b000, i_column};
        w_job_b.line  = i_line;
        w_job_b.last  = 1'b1;
    end

    always_comb begin
        o_push     = (w_acc && (r_held_valid || w_has_b))
                     || (r_pend_valid && !i_q_status.full);
        o_push_job = r_pend_valid ? r_pend : (r_held_valid ? w_job_a : w_job_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_pend_valid <= 1'b0;
            r_held_byte  <= '0;
            r_held_line  <= '0;
            r_held_col   <= '0;
            r_bit_before <= 1'b0;
        end else begin
            if (r_pend_valid && !i_q_status.full) begin
                r_pend_valid <= 1'b0;
            end
            if (w_acc) begin
                if (w_has_b) begin
                    r_held_valid <= 1'b0;
                    if (r_held_valid) begin
                        r_pend_valid <= 1'b1;
                    end
                end else begin
                    r_held_valid <= 1'b1;
                    r_held_byte  <= i_pixel_byte;
                    r_held_line  <= i_line;
                    r_held_col   <= i_column;
                    r_bit_before <= w_prev;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pend <= w_job_b;
        end
    end

endmodule
`default_nettype wire

FILE: design/hcpr_queue.sv
// Short job queue between the front end and the pixel sequencer.
`default_nettype none
module hcpr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hcpr_pkg::t_job i_push_job,
    input  wire logic           i_pop,
    output hcpr_pkg::t_job      o_head,
    output hcpr_pkg::t_q_status o_status
);

    hcpr_pkg::t_job                r_slot [hcpr_pkg::Q_DEPTH];
    logic [hcpr_pkg::Q_AW-1:0]     r_wr;
    logic [hcpr_pkg::Q_AW-1:0]     r_rd;
    logic [hcpr_pkg::Q_CW-1:0]     r_count;
    logic                          w_do_push;
    logic                          w_do_pop;

    assign o_status.full  = (r_count == hcpr_pkg::Q_CW'(hcpr_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr] <= i_push_job;
        end
    end

endmodule
`default_nettype wire

FILE: design/hcpr_back.sv
// Back end: walks the seven pixels of each job into the output register.
`default_nettype none
module hcpr_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hcpr_pkg::t_job              i_head,
    input  wire hcpr_pkg::t_q_status         i_q_status,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [hcpr_pkg::X_W-1:0]         o_pixel_x,
    output logic [hcpr_pkg::LINE_W-1:0]      o_pixel_y,
    output logic [2:0]                       o_colour,
    output logic                             o_last_pixel
);

    hcpr_pkg::t_job             r_job;
    logic                       r_busy;
    logic [hcpr_pkg::IDX_W-1:0] r_idx;

    logic                       w_out_free;
    logic                       w_emit;
    logic                       w_done;
    logic [2:0]                 w_pat;
    logic [hcpr_pkg::X_W-1:0]   w_x;
    hcpr_pkg::t_colour          w_colour;

    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_emit     = r_busy && w_out_free;
    assign w_done     = w_emit && (r_idx == hcpr_pkg::LAST_IDX);
    assign o_pop      = !i_q_status.empty && (!r_busy || w_done);
    assign w_pat      = r_job.win[r_idx +: 3];
    assign w_x        = r_job.xbase + hcpr_pkg::X_W'(r_idx);

    always_comb begin
        w_colour = hcpr_pkg::C_BLACK;
        if (w_pat[1]) begin
            if (w_pat[0] || w_pat[2]) begin
                w_colour = hcpr_pkg::C_WHITE;
            end else if (r_job.group) begin
                w_colour = w_x[0] ? hcpr_pkg::C_ORANGE : hcpr_pkg::C_BLUE;
            end else begin
                w_colour = w_x[0] ? hcpr_pkg::C_GREEN : hcpr_pkg::C_VIOLET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                o_out_valid <= w_emit;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (w_emit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (w_emit) begin
            o_pixel_x    <= w_x;
            o_pixel_y    <= r_job.line;
            o_colour     <= w_colour;
            o_last_pixel <= r_job.last && (r_idx == hcpr_pkg::LAST_IDX);
        end
    end

endmodule
`default_nettype wire

FILE: design/hires_colour_pixel_renderer.sv
// Top level of the hires colour pixel renderer.
// Throughput: one pixel per cycle while jobs are queued and the output is not stalled, set by the pixel sequencer.
// Bytes are taken back to back while the job queue has room; a last-column byte that
// also flushes a held byte blocks input until its own job has been pushed to the queue.
// Reset (synchronous, active low) drops the held byte, empties the queue and clears o_out_valid.
`default_nettype none
module hires_colour_pixel_renderer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Byte channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_pixel_byte,
    input  wire logic [hcpr_pkg::COL_W-1:0]  i_column,
    input  wire logic [hcpr_pkg::LINE_W-1:0] i_line,
    // Pixel channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [hcpr_pkg::X_W-1:0]         o_pixel_x,
    output logic [hcpr_pkg::LINE_W-1:0]      o_pixel_y,
    output logic [2:0]                       o_colour,
    output logic                             o_last_pixel
);

    // Jobs flow front -> queue -> back. Each job is one byte with its full
    // neighbour window already resolved, so the back end never looks at
    // neighbouring bytes.
    logic                w_push;
    hcpr_pkg::t_job      w_push_job;
    logic                w_pop;
    hcpr_pkg::t_job      w_head;
    hcpr_pkg::t_q_status w_q_status;

    // Hold each byte until the next byte arrives; emit at once at or beyond the last column.
    hcpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_byte (i_pixel_byte),
        .i_column     (i_column),
        .i_line       (i_line),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_push_job   (w_push_job)
    );

    // Decouple byte arrival from pixel drawing.
    hcpr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_status   (w_q_status)
    );

    // Draw one pixel per cycle into a registered output; drawing waits while the output is stalled.
    hcpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_colour     (o_colour),
        .o_last_pixel (o_last_pixel)
    );

endmodule
`default_nettype wire

FILE: design/hcpr_checker.sv
// Port-level checks of the renderer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module hcpr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_colour
);

    `HCPR_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "pixel dropped under stall")
    `HCPR_ASSERT(a_colour_range, o_out_valid |-> (o_colour <= 3'd5), "colour code out of range")
    `HCPR_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind hires_colour_pixel_renderer hcpr_checker u_hcpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_colour    (o_colour)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the hires colour pixel renderer: directed rows, random lines.
module tb_top;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BYTES  = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    // One pixel as it leaves the block.
    typedef struct packed {
        logic [hcpr_pkg::X_W-1:0]    x;
        logic [hcpr_pkg::LINE_W-1:0] y;
        hcpr_pkg::t_colour           hue;
        logic                        last;
    } t_pixel;

    // One row of the directed stimulus; hues holds typed-in colours when typed is set.
    typedef struct {
        logic [7:0]                  pbyte;
        logic [hcpr_pkg::COL_W-1:0]  col;
        logic [hcpr_pkg::LINE_W-1:0] ln;
        bit                          typed;
        logic [6:0][2:0]             hues;
    } t_scan_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [7:0]                    i_pixel_byte = '0;
    logic [hcpr_pkg::COL_W-1:0]    i_column = '0;
    logic [hcpr_pkg::LINE_W-1:0]   i_line = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [hcpr_pkg::X_W-1:0]      o_pixel_x;
    logic [hcpr_pkg::LINE_W-1:0]   o_pixel_y;
    logic [2:0]                    o_colour;
    logic                          o_last_pixel;

    // Predictor copy of the byte that waits for its right neighbour.
    logic [7:0]                    pend_byte = '0;
    logic                          pend_valid = 1'b0;
    logic [hcpr_pkg::LINE_W-1:0]   pend_line = '0;
    logic [hcpr_pkg::COL_W-1:0]    pend_col = '0;
    logic                          pend_left = 1'b0;

    t_pixel              expected_pixels[$];
    t_scan_row           scan_rows[$];

    int                  n_errors = 0;
    int                  bytes_sent = 0;
    int                  pixels_checked = 0;
    int                  cycle_count = 0;
    bit                  hold_request = 1'b0;
    bit                  hold_done = 1'b0;

    hires_colour_pixel_renderer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_byte (i_pixel_byte),
        .i_column     (i_column),
        .i_line       (i_line),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_colour     (o_colour),
        .o_last_pixel (o_last_pixel)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Build a 7-pixel colour row: lit pixels on one parity of the bit index, black elsewhere.
    function automatic logic [6:0][2:0] every_other(hcpr_pkg::t_colour hue, bit on_odd);
        logic [6:0][2:0] r;
        for (int i = 0; i < hcpr_pkg::PIXELS_PER_BYTE; i++) begin
            r[i] = ((i % 2) == on_odd) ? hue : hcpr_pkg::C_BLACK;
        end
        return r;
    endfunction

    // Queue the 7 pixels of one byte, judged in its 9-bit window.
    // The window holds the left neighbour in bit 0 and the right neighbour in bit 8.
    function automatic void draw_byte(input logic [7:0] b,
                                      input logic [hcpr_pkg::COL_W-1:0] col,
                                      input logic [hcpr_pkg::LINE_W-1:0] ln, input logic left,
                                      input logic right, input bit typed,
                                      input logic [6:0][2:0] hues);
        logic [8:0] win;
        logic [2:0] pat;
        t_pixel     px;
        win = {right, b[6:0], left};
        for (int i = 0; i < hcpr_pkg::PIXELS_PER_BYTE; i++) begin
            pat     = win[i +: 3];
            px.x    = hcpr_pkg::X_W'(int'(col) * hcpr_pkg::PIXELS_PER_BYTE + i);
            px.y    = ln;
            px.last = 1'b0;
            if (typed) begin
                px.hue = hcpr_pkg::t_colour'(hues[i]);
            end else if (!pat[1]) begin
                px.hue = hcpr_pkg::C_BLACK;
            end else if (pat[0] || pat[2]) begin
                // a lit pixel with a lit neighbour shows white
                px.hue = hcpr_pkg::C_WHITE;
            end else if (b[hcpr_pkg::GROUP_BIT]) begin
                px.hue = px.x[0] ? hcpr_pkg::C_ORANGE : hcpr_pkg::C_BLUE;
            end else begin
                px.hue = px.x[0] ? hcpr_pkg::C_GREEN : hcpr_pkg::C_VIOLET;
            end
            expected_pixels.push_back(px);
        end
    endfunction

    // Work out the pixels that one accepted byte releases and advance the held state.
    function automatic void predict_pixels(input logic [7:0] b,
                                           input logic [hcpr_pkg::COL_W-1:0] col,
                                           input logic [hcpr_pkg::LINE_W-1:0] ln,
                                           input bit typed,
                                           input logic [6:0][2:0] hues);
        int     start_n;
        logic   follows;
        logic   left;
        t_pixel tail;
        start_n = expected_pixels.size();
        // Only the very next column of the same line continues the window.
        follows = pend_valid && (ln == pend_line) && (int'(col) == int'(pend_col) + 1);
        if (pend_valid) begin
            draw_byte(pend_byte, pend_col, pend_line, pend_left, follows ? b[0] : 1'b0,
                      1'b0, '0);
        end
        left = (follows && col != 0) ? pend_byte[6] : 1'b0;
        if (col >= hcpr_pkg::LAST_COL) begin
            // last column or beyond: draw at once with a clear right neighbour
            draw_byte(b, col, ln, left, 1'b0, typed, hues);
            pend_valid = 1'b0;
        end else begin
            pend_byte  = b;
            pend_line  = ln;
            pend_col   = col;
            pend_left  = left;
            pend_valid = 1'b1;
        end
        if (expected_pixels.size() > start_n) begin
            tail      = expected_pixels.pop_back();
            tail.last = 1'b1;
            expected_pixels.push_back(tail);
        end
    endfunction

    // Offer one byte, hold it until the block takes it, then record what it should release.
    task automatic send_byte(input logic [7:0] b, input logic [hcpr_pkg::COL_W-1:0] col,
                             input logic [hcpr_pkg::LINE_W-1:0] ln, input bit typed,
                             input logic [6:0][2:0] hues);
        i_in_valid   <= 1'b1;
        i_pixel_byte <= b;
        i_column     <= col;
        i_line       <= ln;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_pixels(b, col, ln, typed, hues);
        bytes_sent++;
    endtask

    // Drop valid for a gap of random length; mostly none, sometimes short, rarely long.
    task automatic idle_sender(input bit steady);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!steady) begin
            if (r >= 50 && r < 90) gap = $urandom_range(1, 3);
            else if (r >= 90) gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering bytes until every expected pixel has come out.
    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Pixel receiver: stall in runs of random length, plus one long hold-off on request.
    initial begin
        int r;
        int len;
        forever begin
            if (hold_request && !hold_done) begin
                // hold off long enough for the job queue to fill and the input to stall
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_stall <= 1'b0;
                    len = $urandom_range(1, 12);
                end else if (r < 90) begin
                    i_out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else if (r < 97) begin
                    i_out_stall <= 1'b1;
                    len = $urandom_range(10, 30);
                end else begin
                    i_out_stall <= 1'b0;
                    len = $urandom_range(40, 80);
                end
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // Compare every accepted pixel with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d colour=%0d last=%0b",
                         $time, o_pixel_x, o_pixel_y, o_colour, o_last_pixel);
                n_errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x !== want.x || o_pixel_y !== want.y
                        || o_colour !== want.hue || o_last_pixel !== want.last) begin
                    $display("%0t: pixel mismatch expected x=%0d y=%0d colour=%0d last=%0b",
                             $time, want.x, want.y, want.hue, want.last);
                    $display("%0t:                 actual   x=%0d y=%0d colour=%0d last=%0b",
                             $time, o_pixel_x, o_pixel_y, o_colour, o_last_pixel);
                    n_errors++;
                end
            end
            pixels_checked++;
        end
    end

    // Watchdog: end the run if it stalls far beyond the slowest correct run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d pixels still expected", $time, expected_pixels.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Byte sender: reset, directed rows, random scan lines, then drain and report.
    initial begin
        int                          random_sent;
        int                          start_col;
        int                          stop_col;
        int                          kind;
        bit                          steady;
        bit                          paused;
        logic [hcpr_pkg::LINE_W-1:0] run_line;
        logic [7:0]                  rand_byte;

        // Typed-in rows are bytes at or beyond the last column with nothing held, so only their own
        // seven pixels come out and the colours can be read straight off the bits.
        scan_rows.push_back('{8'h00, 6'd39, 8'd0,   1'b1, {7{hcpr_pkg::C_BLACK}}});
        scan_rows.push_back('{8'h7F, 6'd39, 8'd191, 1'b1, {7{hcpr_pkg::C_WHITE}}});
        scan_rows.push_back('{8'hFF, 6'd39, 8'd255, 1'b1, {7{hcpr_pkg::C_WHITE}}});
        // x starts odd at column 39, so even bit indexes land on odd x
        scan_rows.push_back('{8'h55, 6'd39, 8'd1,   1'b1,
                              every_other(hcpr_pkg::C_GREEN, 1'b0)});
        // beyond the line: column 63 is drawn at once
        scan_rows.push_back('{8'hD5, 6'd63, 8'd2,   1'b1,
                              every_other(hcpr_pkg::C_ORANGE, 1'b0)});
        scan_rows.push_back('{8'h2A, 6'd39, 8'd3,   1'b1,
                              every_other(hcpr_pkg::C_VIOLET, 1'b1)});
        // column 40 starts at an even x
        scan_rows.push_back('{8'hAA, 6'd40, 8'd4,   1'b1,
                              every_other(hcpr_pkg::C_ORANGE, 1'b1)});
        // column zero, then a lit pair across a byte boundary
        scan_rows.push_back('{8'h01, 6'd0,  8'd5,   1'b0, '0});
        scan_rows.push_back('{8'hC0, 6'd1,  8'd5,   1'b0, '0});
        scan_rows.push_back('{8'h01, 6'd2,  8'd5,   1'b0, '0});
        // line change, column gap and a jump near the end break the sequence
        scan_rows.push_back('{8'h00, 6'd3,  8'd6,   1'b0, '0});
        scan_rows.push_back('{8'h7F, 6'd4,  8'd6,   1'b0, '0});
        scan_rows.push_back('{8'h3E, 6'd10, 8'd6,   1'b0, '0});
        scan_rows.push_back('{8'h40, 6'd38, 8'd7,   1'b0, '0});
        scan_rows.push_back('{8'h01, 6'd39, 8'd7,   1'b0, '0});
        // same column twice, then a regular continuation
        scan_rows.push_back('{8'h80, 6'd0,  8'd0,   1'b0, '0});
        scan_rows.push_back('{8'h7F, 6'd0,  8'd0,   1'b0, '0});
        scan_rows.push_back('{8'h2A, 6'd1,  8'd0,   1'b0, '0});
        scan_rows.push_back('{8'hFF, 6'd39, 8'd0,   1'b0, '0});
        // column going backward while a byte is held
        scan_rows.push_back('{8'h55, 6'd38, 8'd200, 1'b0, '0});
        scan_rows.push_back('{8'hAA, 6'd0,  8'd200, 1'b0, '0});
        scan_rows.push_back('{8'h00, 6'd39, 8'd200, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (scan_rows[k]) begin
            send_byte(scan_rows[k].pbyte, scan_rows[k].col, scan_rows[k].ln,
                      scan_rows[k].typed, scan_rows[k].hues);
            idle_sender(1'b0);
        end
        drain_pixels();

        // Random part: mostly runs of consecutive columns ending at the last column,
        // some broken off early, the rest single bytes anywhere in the column range.
        hold_request = 1'b1;
        random_sent  = 0;
        paused       = 1'b0;
        while (random_sent < RANDOM_BYTES) begin
            kind   = $urandom_range(0, 9);
            steady = ($urandom_range(0, 2) == 0);
            if (kind <= 6) begin
                run_line  = hcpr_pkg::LINE_W'($urandom_range(0, 255));
                start_col = (kind == 0) ? 0 :
                            $urandom_range(26, hcpr_pkg::BYTES_PER_LINE - 1);
                stop_col  = hcpr_pkg::BYTES_PER_LINE - 1;
                if ($urandom_range(0, 4) == 0) stop_col = $urandom_range(start_col, stop_col);
                for (int c = start_col; c <= stop_col && random_sent < RANDOM_BYTES; c++) begin
                    rand_byte = 8'($urandom);
                    send_byte(rand_byte, hcpr_pkg::COL_W'(c), run_line, 1'b0, '0);
                    random_sent++;
                    idle_sender(steady);
                end
            end else begin
                rand_byte = 8'($urandom);
                send_byte(rand_byte, hcpr_pkg::COL_W'($urandom_range(0, 63)),
                          hcpr_pkg::LINE_W'($urandom_range(0, 255)), 1'b0, '0);
                random_sent++;
                idle_sender(1'b0);
            end
            if (!paused && random_sent >= RANDOM_BYTES / 2) begin
                drain_pixels();
                paused = 1'b1;
            end
        end

        // Flush whatever byte is still held with a byte at or beyond the last column.
        send_byte(8'($urandom),
                  hcpr_pkg::COL_W'($urandom_range(hcpr_pkg::BYTES_PER_LINE - 1, 63)),
                  hcpr_pkg::LINE_W'($urandom_range(0, 255)), 1'b0, '0);
        drain_pixels();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d directed rows) and checked %0d pixels.",
                 bytes_sent, scan_rows.size(), pixels_checked);
        $display("Covered edge columns, broken sequences, beyond-line columns and long hold-off.");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/hcpr_pkg.sv
design/hcpr_front.sv
design/hcpr_queue.sv
design/hcpr_back.sv
design/hires_colour_pixel_renderer.sv
design/hcpr_checker.sv
tb/sv/tb_top.sv
